/* src/hcm_pkg.sv */
package hcm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int FIELD_W          = 16;
    localparam int GUARD_BITS       = 24;
    localparam int GROWTH_BITS      = 3;
    localparam int TAB_LEN          = 24;
    localparam int Z_W              = 32;
    localparam int SUM_W            = Z_W + 2;
    localparam int FRAC_W           = 16;
    localparam int H_W              = SUM_W - FRAC_W;

    localparam logic signed [Z_W-1:0]   HALF_TURN_Z = 32'sd1179648000;
    localparam logic signed [SUM_W-1:0] ROUND_HALF  = 34'sd32768;
    localparam logic signed [H_W-1:0]   FULL_TURN   = 18'sd36000;
    localparam logic signed [H_W-1:0]   TWO_TURNS   = 18'sd72000;

    localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
        32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
        32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
        32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
        32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
        32'sd358,       32'sd179,       32'sd90,       32'sd45
    };

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

/* src/hcm_prep.sv */
module hcm_prep #(
    parameter int SAMPLE_BITS = 16,
    parameter int W           = 43
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [hcm_pkg::FIELD_W-1:0]   i_mag_x,
    input  logic [hcm_pkg::FIELD_W-1:0]   i_mag_y,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic signed [hcm_pkg::Z_W-1:0] o_z,
    output hcm_pkg::t_ctl                 o_ctl
);
    import hcm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] w_sx;
    logic signed [SAMPLE_BITS-1:0] w_sy;
    logic signed [W-1:0]           w_ex;
    logic signed [W-1:0]           w_ey;
    logic signed [W-1:0]           n_x;
    logic signed [W-1:0]           n_y;
    logic signed [Z_W-1:0]         n_z;
    t_ctl                          n_ctl;
    logic signed [W-1:0]           r_x;
    logic signed [W-1:0]           r_y;
    logic signed [Z_W-1:0]         r_z;
    t_ctl                          r_ctl;

    generate
        if (SAMPLE_BITS <= FIELD_W) begin : g_trunc
            assign w_sx = $signed(i_mag_x[SAMPLE_BITS-1:0]);
            assign w_sy = $signed(i_mag_y[SAMPLE_BITS-1:0]);
        end else begin : g_zext
            assign w_sx = $signed({{(SAMPLE_BITS-FIELD_W){1'b0}}, i_mag_x});
            assign w_sy = $signed({{(SAMPLE_BITS-FIELD_W){1'b0}}, i_mag_y});
        end
    endgenerate

    assign w_ex = W'(w_sx);
    assign w_ey = W'(w_sy);

    // turn the left half plane by a half turn, vector is (x, -y)
    always_comb begin
        if (w_sx[SAMPLE_BITS-1]) begin
            n_x = (-w_ex) <<< GUARD_BITS;
            n_y = w_ey <<< GUARD_BITS;
            n_z = HALF_TURN_Z;
        end else begin
            n_x = w_ex <<< GUARD_BITS;
            n_y = (-w_ey) <<< GUARD_BITS;
            n_z = '0;
        end
        n_ctl.valid = i_valid;
        n_ctl.zero  = (w_sx == '0) && (w_sy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_ctl = r_ctl;

endmodule

/* src/hcm_cell.sv */
module hcm_cell #(
    parameter int W    = 43,
    parameter int STEP = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic signed [W-1:0]            i_x,
    input  logic signed [W-1:0]            i_y,
    input  logic signed [hcm_pkg::Z_W-1:0] i_z,
    input  hcm_pkg::t_ctl                  i_ctl,
    output logic signed [W-1:0]            o_x,
    output logic signed [W-1:0]            o_y,
    output logic signed [hcm_pkg::Z_W-1:0] o_z,
    output hcm_pkg::t_ctl                  o_ctl
);
    import hcm_pkg::*;

    logic signed [W-1:0]   w_dx;
    logic signed [W-1:0]   w_dy;
    logic signed [W-1:0]   n_x;
    logic signed [W-1:0]   n_y;
    logic signed [Z_W-1:0] n_z;
    logic signed [W-1:0]   r_x;
    logic signed [W-1:0]   r_y;
    logic signed [Z_W-1:0] r_z;
    t_ctl                  r_ctl;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    // rotate toward the x axis, accumulate the step angle
    always_comb begin
        if (!i_y[W-1]) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN_TAB[STEP];
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_ctl = r_ctl;

endmodule

/* src/hcm_wrap.sv */
module hcm_wrap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic signed [hcm_pkg::Z_W-1:0] i_z,
    input  hcm_pkg::t_ctl                  i_ctl,
    input  logic signed [15:0]             i_offset,
    output logic                           o_valid,
    output logic [15:0]                    o_heading
);
    import hcm_pkg::*;

    logic signed [Z_W-1:0]   w_z;
    logic signed [SUM_W-1:0] w_total;
    logic signed [H_W-1:0]   n_h;
    logic signed [H_W-1:0]   n_wrap;
    logic signed [H_W-1:0]   r_h;
    logic                    r_v1;
    logic [15:0]             r_heading;
    logic                    r_v2;

    assign w_z = i_ctl.zero ? '0 : i_z;

    // add offset, round half up to hundredths
    always_comb begin
        w_total = SUM_W'(w_z) + $signed({{2{i_offset[15]}}, i_offset, 16'h0}) + ROUND_HALF;
        n_h     = $signed(w_total[SUM_W-1:FRAC_W]);
    end

    always_comb begin
        if (r_h < -FULL_TURN) begin
            n_wrap = r_h + TWO_TURNS;
        end else if (r_h < 0) begin
            n_wrap = r_h + FULL_TURN;
        end else if (r_h >= FULL_TURN) begin
            n_wrap = r_h - FULL_TURN;
        end else begin
            n_wrap = r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_h       <= n_h;
            r_heading <= n_wrap[15:0];
        end
    end

    assign o_valid   = r_v2;
    assign o_heading = r_heading;

endmodule

/* src/compass_heading_from_magnetometer_unit.sv */
// Compass heading from one magnetometer word: the angle of (X, -Y) by a
// vectoring CORDIC, plus the programmed offset, rounded to hundredths of a
// degree and wrapped into 0..35999. One word is accepted per cycle while the
// output is not stalled; the pipeline is the input stage, one register per
// CORDIC cell and two stages for offset add and wrap. The whole pipeline
// holds while the output word is stalled.
module compass_heading_from_magnetometer_unit #(
    parameter int CORDIC_STEPS = hcm_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = hcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [15:0]                 i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [hcm_pkg::FIELD_W-1:0] i_mag_x,
    input  logic [hcm_pkg::FIELD_W-1:0] i_mag_y,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [15:0]                 o_heading
);
    import hcm_pkg::*;

    localparam int W = SAMPLE_BITS + GUARD_BITS + GROWTH_BITS;

    logic                  w_adv;
    logic signed [15:0]    r_offset;
    logic signed [W-1:0]   w_x   [CORDIC_STEPS+1];
    logic signed [W-1:0]   w_y   [CORDIC_STEPS+1];
    logic signed [Z_W-1:0] w_z   [CORDIC_STEPS+1];
    t_ctl                  w_ctl [CORDIC_STEPS+1];

    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= $signed(i_cfg_wdata);
        end
    end

    hcm_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .W           (W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_mag_x (i_mag_x),
        .i_mag_y (i_mag_y),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0]),
        .o_ctl   (w_ctl[0])
    );

    generate
        for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
            hcm_cell #(
                .W    (W),
                .STEP (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_x     (w_x[g]),
                .i_y     (w_y[g]),
                .i_z     (w_z[g]),
                .i_ctl   (w_ctl[g]),
                .o_x     (w_x[g+1]),
                .o_y     (w_y[g+1]),
                .o_z     (w_z[g+1]),
                .o_ctl   (w_ctl[g+1])
            );
        end
    endgenerate

    hcm_wrap u_wrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_z       (w_z[CORDIC_STEPS]),
        .i_ctl     (w_ctl[CORDIC_STEPS]),
        .i_offset  (r_offset),
        .o_valid   (o_valid),
        .o_heading (o_heading)
    );

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading < 16'd36000))
        else $error("heading out of range");

    a_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[CORDIC_STEPS].valid |-> !w_x[CORDIC_STEPS][W-1])
        else $error("cordic x went negative");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
